// ===== hw/rtl/rsi_pkg.sv =====
// Package for the relative strength index unit: fixed widths, constants and
// the control structs passed between the sequencer and the shared divider.
// No dependencies.
package rsi_pkg;

	// Fixed field and state widths.
	localparam int ACC_W       = 64;
	localparam int PERIOD_W    = 16;
	localparam int COUNT_W     = 17;
	localparam int RSI_W       = 23;
	localparam int SRC_PRICE_W = 32;
	localparam int DIV_CNT_W   = 7;

	// The ratio numerator is G * 100 * 2^16 = (G * 25) << 18.
	localparam int RATIO_MUL_W   = ACC_W + 5;
	localparam int RATIO_PRE_SH  = 5;

	localparam logic [RSI_W-1:0]     RSI_FULL_SCALE = 23'd6553600;
	localparam logic [PERIOD_W-1:0]  PERIOD_RESET   = 16'd14;
	localparam logic [DIV_CNT_W-1:0] DIV_STEPS_FULL = 7'd64;
	localparam logic [DIV_CNT_W-1:0] RATIO_STEPS    = 7'd23;

	// Command from the sequencer to the divider.
	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] steps;
	} div_cmd_t;

	// Status from the divider back to the sequencer.
	typedef struct packed {
		logic done;
	} div_stat_t;

endpackage

// ===== hw/rtl/rsi_tick_if.sv =====
// Input channel of the relative strength index unit: one price beat.
// Depends on rsi_pkg.
interface rsi_tick_if import rsi_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [SRC_PRICE_W-1:0] price;
	logic                   restart;

	modport source (output valid, price, restart, input ready);
	modport sink (input valid, price, restart, output ready);
endinterface

// ===== hw/rtl/rsi_result_if.sv =====
// Output channel of the relative strength index unit: one index beat.
// Depends on rsi_pkg.
interface rsi_result_if import rsi_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RSI_W-1:0] rsi_value;
	logic             ready_res;

	modport source (output valid, rsi_value, ready_res, input ready);
	modport sink (input valid, rsi_value, ready_res, output ready);
endinterface

// ===== hw/rtl/rsi_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, shared by the
// period divisions and the index ratio. Depends on rsi_pkg.
module rsi_div import rsi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_cmd_t         cmd,
	input  logic [ACC_W-1:0] rem_init,
	input  logic [ACC_W-1:0] dividend,
	input  logic [ACC_W-1:0] divisor,
	output div_stat_t        stat,
	output logic [ACC_W-1:0] quotient,
	output logic [ACC_W-1:0] remainder
);

	logic [ACC_W-1:0]     rem_q;
	logic [ACC_W-1:0]     num_q;
	logic [ACC_W-1:0]     den_q;
	logic [ACC_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [ACC_W:0]   trial;
	logic [ACC_W+1:0] diff;
	logic             take;
	logic [ACC_W-1:0] rem_next;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	always_comb begin
		trial    = {rem_q, num_q[ACC_W-1]};
		diff     = {1'b0, trial} - {2'b00, den_q};
		take     = !diff[ACC_W+1];
		rem_next = take ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
	end

	// Iteration registers: the dividend leaves MSB first, the quotient enters LSB first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			num_q  <= '0;
			den_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				rem_q  <= rem_init;
				num_q  <= dividend;
				den_q  <= divisor;
				quo_q  <= '0;
				cnt_q  <= cmd.steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= rem_next;
				num_q <= {num_q[ACC_W-2:0], 1'b0};
				quo_q <= {quo_q[ACC_W-2:0], take};
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== hw/rtl/relative_strength_index_unit.sv =====
// Top level of the Wilder relative strength index unit: sequencer, state and
// output register. Depends on rsi_pkg, rsi_tick_if, rsi_result_if and rsi_div.
//
//   channel   direction  beat contents            handshake
//   tick      in         price, restart           valid/ready
//   rsi       out        rsi_value, ready_res     valid/ready
//   period    in         period_wdata             period_we, no ready
//
// One price is worked on at a time. A restart beat, or a beat in the summing
// phase, goes through no division; the beat that closes the first period or
// any smoothing beat waits on the radix-2 divider, which produces one quotient
// bit per cycle (64 bits for each of the two averages, 23 bits for the ratio
// when the index needs one). A new beat is taken while the previous result
// waits in the output register; a stalled output holds the sequencer in its
// final state. Reset clears the series state and sets the period to 14.
module relative_strength_index_unit import rsi_pkg::*; #(
	parameter int PRICE_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	rsi_tick_if.sink            tick,
	rsi_result_if.source        rsi,
	input  logic                period_we,
	input  logic [PERIOD_W-1:0] period_wdata
);

	// Stored price width; prices wider than the port cannot arrive.
	localparam int PW = (PRICE_BITS < SRC_PRICE_W) ? PRICE_BITS : SRC_PRICE_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DSTART,
		ST_DWAIT,
		ST_RATIO,
		ST_RSTART,
		ST_RWAIT,
		ST_EMIT
	} state_t;

	state_t              state_q;
	logic [PERIOD_W-1:0] period_q;
	logic [PW-1:0]       price_q;
	logic                restart_q;
	logic [PW-1:0]       prev_q;
	logic [COUNT_W-1:0]  count_q;
	logic [ACC_W-1:0]    gain_q;
	logic [ACC_W-1:0]    loss_q;
	logic [ACC_W-1:0]    xg_q;
	logic [ACC_W-1:0]    xl_q;
	logic                smooth_q;
	logic                loss_sel_q;
	logic                up_q;
	logic [ACC_W-1:0]    rnum_q;
	logic [ACC_W-1:0]    rden_q;
	logic [RSI_W-1:0]    rsi_q;
	logic                rdy_q;
	logic                out_valid_q;
	logic [RSI_W-1:0]    out_rsi_q;
	logic                out_rdy_q;

	logic [PERIOD_W-1:0]    p;
	logic [COUNT_W-1:0]     p_ext;
	logic [COUNT_W-1:0]     p1;
	logic [COUNT_W-1:0]     idx;
	logic [COUNT_W-1:0]     cnt_next;
	logic                   new_series;
	logic                   in_sum;
	logic                   at_end;
	logic                   rise;
	logic [PW-1:0]          pdiff;
	logic [ACC_W-1:0]       fixed_chg;
	logic [ACC_W-1:0]       g_in;
	logic [ACC_W-1:0]       l_in;
	logic [ACC_W-1:0]       gsum;
	logic [ACC_W-1:0]       lsum;
	logic [ACC_W-1:0]       acc_cur;
	logic [ACC_W-1:0]       x_cur;
	logic                   up;
	logic [ACC_W-1:0]       avg_op;
	logic [ACC_W-1:0]       avg_new;
	logic [ACC_W:0]         rsum;
	logic [ACC_W-1:0]       rsum_half;
	logic [RATIO_MUL_W-1:0] rmul;
	logic                   slot_free;
	div_cmd_t               dcmd;
	div_stat_t              dstat;
	logic [ACC_W-1:0]       d_rem_init;
	logic [ACC_W-1:0]       d_dividend;
	logic [ACC_W-1:0]       d_divisor;
	logic [ACC_W-1:0]       d_quo;
	logic [ACC_W-1:0]       d_rem;

	// Saturating 64-bit add.
	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
			input logic [ACC_W-1:0] b);
		logic [ACC_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ACC_W] ? '1 : s[ACC_W-1:0];
	endfunction

	// Period handling and the position of this change in the series.
	always_comb begin
		p          = (period_q == '0) ? PERIOD_W'(1) : period_q;
		p_ext      = {1'b0, p};
		p1         = p_ext + COUNT_W'(1);
		idx        = (count_q > p1) ? p1 : count_q;
		new_series = restart_q || (idx == '0);
		in_sum     = idx <= p_ext;
		at_end     = idx == p_ext;
		cnt_next   = (idx == p1) ? p1 : idx + COUNT_W'(1);
	end

	// Split the price change into a gain and a loss in fixed point; the shifted
	// change always fits the accumulator width, so no saturation is needed here.
	always_comb begin
		rise      = price_q > prev_q;
		pdiff     = rise ? price_q - prev_q : prev_q - price_q;
		fixed_chg = ACC_W'(pdiff) << FRAC_BITS;
		g_in      = rise ? fixed_chg : '0;
		l_in      = rise ? '0 : fixed_chg;
		gsum      = sat_add(gain_q, g_in);
		lsum      = sat_add(loss_q, l_in);
	end

	// Operand for a period division and the average it yields.
	always_comb begin
		acc_cur = loss_sel_q ? loss_q : gain_q;
		x_cur   = loss_sel_q ? xl_q : xg_q;
		up      = x_cur >= acc_cur;
		if (!smooth_q) begin
			avg_op = acc_cur;
		end else if (up) begin
			avg_op = x_cur - acc_cur;
		end else begin
			avg_op = acc_cur - x_cur;
		end
		if (!smooth_q) begin
			avg_new = d_quo;
		end else if (up_q) begin
			avg_new = acc_cur + d_quo;
		end else begin
			avg_new = acc_cur - d_quo - ACC_W'(d_rem != '0);
		end
	end

	// Ratio operands: halve both averages when their sum overflows, then scale
	// the numerator by 25 (the remaining factor 2^18 comes from the step count).
	always_comb begin
		rsum      = {1'b0, gain_q} + {1'b0, loss_q};
		rsum_half = (gain_q >> 1) + (loss_q >> 1);
		rmul      = (RATIO_MUL_W'(rnum_q) << 4) + (RATIO_MUL_W'(rnum_q) << 3)
			+ RATIO_MUL_W'(rnum_q);
	end

	// Divider command: a full-width division by the period, or the last
	// quotient bits of the ratio starting from the known partial remainder.
	always_comb begin
		dcmd.start = (state_q == ST_DSTART) || (state_q == ST_RSTART);
		if (state_q == ST_RSTART) begin
			dcmd.steps = RATIO_STEPS;
			d_rem_init = rmul[RATIO_MUL_W-1:RATIO_PRE_SH];
			d_dividend = {rmul[RATIO_PRE_SH-1:0], {(ACC_W-RATIO_PRE_SH){1'b0}}};
			d_divisor  = rden_q;
		end else begin
			dcmd.steps = DIV_STEPS_FULL;
			d_rem_init = '0;
			d_dividend = avg_op;
			d_divisor  = ACC_W'(p);
		end
	end

	rsi_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dcmd),
		.rem_init  (d_rem_init),
		.dividend  (d_dividend),
		.divisor   (d_divisor),
		.stat      (dstat),
		.quotient  (d_quo),
		.remainder (d_rem)
	);

	// Period register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (period_we) begin
			period_q <= period_wdata;
		end
	end

	assign slot_free = !out_valid_q || rsi.ready;

	// Output valid: set when a result is loaded, cleared when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (rsi.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer with series state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			price_q     <= '0;
			restart_q   <= 1'b0;
			prev_q      <= '0;
			count_q     <= '0;
			gain_q      <= '0;
			loss_q      <= '0;
			xg_q        <= '0;
			xl_q        <= '0;
			smooth_q    <= 1'b0;
			loss_sel_q  <= 1'b0;
			up_q        <= 1'b0;
			rnum_q      <= '0;
			rden_q      <= '0;
			rsi_q       <= '0;
			rdy_q       <= 1'b0;
			out_rsi_q   <= '0;
			out_rdy_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (tick.valid) begin
						price_q   <= tick.price[PW-1:0];
						restart_q <= tick.restart;
						state_q   <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					prev_q     <= price_q;
					loss_sel_q <= 1'b0;
					if (new_series) begin
						count_q <= COUNT_W'(1);
						gain_q  <= '0;
						loss_q  <= '0;
						state_q <= ST_RATIO;
					end else begin
						xg_q    <= g_in;
						xl_q    <= l_in;
						count_q <= cnt_next;
						if (in_sum) begin
							gain_q   <= gsum;
							loss_q   <= lsum;
							smooth_q <= 1'b0;
							state_q  <= at_end ? ST_DSTART : ST_RATIO;
						end else begin
							smooth_q <= 1'b1;
							state_q  <= ST_DSTART;
						end
					end
				end
				ST_DSTART: begin
					up_q    <= up;
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (dstat.done) begin
						if (loss_sel_q) begin
							loss_q  <= avg_new;
							state_q <= ST_RATIO;
						end else begin
							gain_q     <= avg_new;
							loss_sel_q <= 1'b1;
							state_q    <= ST_DSTART;
						end
					end
				end
				ST_RATIO: begin
					rdy_q <= count_q > p_ext;
					if (!(count_q > p_ext) || (gain_q == '0)) begin
						rsi_q   <= (count_q > p_ext && loss_q == '0) ? RSI_FULL_SCALE : '0;
						state_q <= ST_EMIT;
					end else if (loss_q == '0) begin
						rsi_q   <= RSI_FULL_SCALE;
						state_q <= ST_EMIT;
					end else begin
						if (rsum[ACC_W]) begin
							rnum_q <= gain_q >> 1;
							rden_q <= rsum_half;
						end else begin
							rnum_q <= gain_q;
							rden_q <= rsum[ACC_W-1:0];
						end
						state_q <= ST_RSTART;
					end
				end
				ST_RSTART: begin
					state_q <= ST_RWAIT;
				end
				ST_RWAIT: begin
					if (dstat.done) begin
						rsi_q   <= d_quo[RSI_W-1:0];
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_rsi_q   <= rsi_q;
						out_rdy_q   <= rdy_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign tick.ready    = (state_q == ST_IDLE);
	assign rsi.valid     = out_valid_q;
	assign rsi.rsi_value = out_rsi_q;
	assign rsi.ready_res = out_rdy_q;

endmodule

// ===== tb/relative_strength_index_unit_tb.sv =====
// Testbench for the relative strength index unit: sends price beats with random idling
// on both channels, predicts every index beat and checks it field by field.
// Depends on rsi_pkg, rsi_tick_if, rsi_result_if and relative_strength_index_unit.
module relative_strength_index_unit_tb;
	import rsi_pkg::*;

	localparam int PRICE_BITS   = 32;
	localparam int FRAC_BITS    = 16;
	localparam int IDLE_LIMIT   = 20000;
	localparam int DRAIN_CYCLES = 200;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [RSI_W-1:0] rsi_value;
		logic             ready_res;
	} rsi_beat_t;

	// Shapes of the price series that the random part produces.
	typedef enum int {WALK_NOISE, WALK_SMALL, WALK_UP, WALK_DOWN, WALK_FLAT} walk_t;

	logic                clk;
	logic                arst_n;
	logic                period_we;
	logic [PERIOD_W-1:0] period_wdata;

	rsi_tick_if   tick_ch ();
	rsi_result_if rsi_ch ();

	relative_strength_index_unit #(
		.PRICE_BITS(PRICE_BITS),
		.FRAC_BITS (FRAC_BITS)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (tick_ch),
		.rsi         (rsi_ch),
		.period_we   (period_we),
		.period_wdata(period_wdata)
	);

	// Predicted series state and the configured period.
	logic [PERIOD_W-1:0]    model_period;
	logic [SRC_PRICE_W-1:0] model_last_price;
	logic [COUNT_W-1:0]     model_seen;
	logic [ACC_W-1:0]       model_gain_avg;
	logic [ACC_W-1:0]       model_loss_avg;

	rsi_beat_t              rsi_expected[$];
	int unsigned            mismatch_count;
	int unsigned            idle_cycles;
	bit                     hold_request;
	int unsigned            hold_cycles;
	bit                     no_idle;
	logic [SRC_PRICE_W-1:0] walk_price;

	always #6 clk = ~clk;

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int unsigned idle_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 20);
		return $urandom_range(30, 150);
	endfunction

	function automatic logic [ACC_W-1:0] sat_sum(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
		logic [ACC_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ACC_W] ? '1 : s[ACC_W-1:0];
	endfunction

	// Wilder smoothing, floor((avg * (p - 1) + x) / p), without the wide product.
	function automatic logic [ACC_W-1:0] wilder_step(logic [ACC_W-1:0] avg,
			logic [ACC_W-1:0] x, logic [ACC_W-1:0] p);
		logic [ACC_W-1:0] d;
		if (x >= avg)
			return avg + (x - avg) / p;
		d = avg - x;
		return avg - (d / p + ACC_W'((d % p) != 0));
	endfunction

	// Advances the series state by one price and returns the index beat it yields.
	function automatic rsi_beat_t predict_rsi(logic [SRC_PRICE_W-1:0] price_in,
			logic restart_in);
		logic [COUNT_W:0]       p;
		logic [COUNT_W:0]       idx;
		logic [SRC_PRICE_W-1:0] price;
		logic [SRC_PRICE_W-1:0] delta;
		logic [ACC_W-1:0]       fixed_move;
		logic [ACC_W-1:0]       gain_in;
		logic [ACC_W-1:0]       loss_in;
		logic [ACC_W-1:0]       g;
		logic [ACC_W-1:0]       l;
		logic [ACC_W:0]         total;
		logic [2*ACC_W-1:0]     num;
		logic [2*ACC_W-1:0]     quotient;
		rsi_beat_t              beat;
		price = price_in & SRC_PRICE_W'((64'd1 << PRICE_BITS) - 1);
		p = {2'b00, model_period};
		if (p == 0)
			p = (COUNT_W+1)'(1);
		beat = '0;
		// A shorter period clamps the count of prices seen.
		if (model_seen > p + 1)
			model_seen = COUNT_W'(p + 1);

		if (restart_in || model_seen == '0) begin
			model_seen     = COUNT_W'(1);
			model_gain_avg = '0;
			model_loss_avg = '0;
		end else begin
			idx   = {1'b0, model_seen};
			delta = (price > model_last_price) ? price - model_last_price
			                                   : model_last_price - price;
			if ((ACC_W'(delta) >> (ACC_W - FRAC_BITS)) != 0)
				fixed_move = '1;
			else
				fixed_move = ACC_W'(delta) << FRAC_BITS;
			gain_in = (price > model_last_price) ? fixed_move : '0;
			loss_in = (price > model_last_price) ? '0 : fixed_move;
			// Sum over the first period, then average; smooth afterwards.
			if (idx <= p) begin
				model_gain_avg = sat_sum(model_gain_avg, gain_in);
				model_loss_avg = sat_sum(model_loss_avg, loss_in);
				if (idx == p) begin
					model_gain_avg = model_gain_avg / p;
					model_loss_avg = model_loss_avg / p;
				end
			end else begin
				model_gain_avg = wilder_step(model_gain_avg, gain_in, ACC_W'(p));
				model_loss_avg = wilder_step(model_loss_avg, loss_in, ACC_W'(p));
			end
			model_seen = COUNT_W'((idx + 1 > p + 1) ? p + 1 : idx + 1);
		end
		model_last_price = price;

		// Index once more than a period of prices has been seen.
		if (model_seen > p) begin
			beat.ready_res = 1'b1;
			if (model_loss_avg == '0) begin
				beat.rsi_value = RSI_FULL_SCALE;
			end else if (model_gain_avg == '0) begin
				beat.rsi_value = '0;
			end else begin
				g = model_gain_avg;
				l = model_loss_avg;
				total = {1'b0, g} + {1'b0, l};
				if (total[ACC_W]) begin
					g = g >> 1;
					l = l >> 1;
					total = {1'b0, g} + {1'b0, l};
				end
				num = {{ACC_W{1'b0}}, g};
				num = num * RSI_FULL_SCALE;
				quotient = num / {{(ACC_W-1){1'b0}}, total};
				beat.rsi_value = quotient[RSI_W-1:0];
			end
		end
		return beat;
	endfunction

	function automatic logic [SRC_PRICE_W-1:0] next_price(walk_t mode,
			logic [SRC_PRICE_W-1:0] last);
		logic [SRC_PRICE_W-1:0] step;
		bit                     up;
		step = SRC_PRICE_W'($urandom_range(0, 32'd1 << $urandom_range(0, 24)));
		case (mode)
			WALK_NOISE: return $urandom();
			WALK_UP: up = ($urandom_range(0, 3) != 0);
			WALK_DOWN: up = ($urandom_range(0, 3) == 0);
			WALK_FLAT: begin
				if ($urandom_range(0, 2) != 0)
					return last;
				up = ($urandom_range(0, 1) != 0);
			end
			default: up = ($urandom_range(0, 1) != 0);
		endcase
		if (up)
			return (last > '1 - step) ? '1 : last + step;
		return (last < step) ? '0 : last - step;
	endfunction

	task automatic note_mismatch(string what, rsi_beat_t want, rsi_beat_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t %s: expected rsi_value %0d ready_res %0b, got rsi_value %0d ready_res %0b",
				$time, what, want.rsi_value, want.ready_res, got.rsi_value, got.ready_res);
	endtask

	// Sends one price beat after a random gap and records its expected index beat.
	task automatic send_tick(logic [SRC_PRICE_W-1:0] price, logic restart);
		int unsigned gap;
		gap = no_idle ? 0 : idle_len();
		repeat (gap) begin
			@(negedge clk);
			tick_ch.valid = 1'b0;
		end
		@(negedge clk);
		tick_ch.valid   = 1'b1;
		tick_ch.price   = price;
		tick_ch.restart = restart;
		forever begin
			@(posedge clk);
			if (tick_ch.ready)
				break;
		end
		rsi_expected.push_back(predict_rsi(price, restart));
		walk_price = price;
	endtask

	// Drops the input valid and waits until every expected beat has come back.
	task automatic wait_drained();
		@(negedge clk);
		tick_ch.valid = 1'b0;
		while (rsi_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_period(logic [PERIOD_W-1:0] value);
		wait_drained();
		@(negedge clk);
		period_we    = 1'b1;
		period_wdata = value;
		@(negedge clk);
		period_we    = 1'b0;
		model_period = value;
	endtask

	// Reset period: a series opened without restart, a zero change, the full
	// rise that closes the period with no loss, then a fall, a rise and a restart.
	task automatic test_reset_defaults();
		logic [SRC_PRICE_W-1:0] px;
		px = '0;
		send_tick(px, 1'b0);
		for (int i = 1; i <= 13; i++) begin
			if (i != 7)
				px = px + (SRC_PRICE_W'(i) << 20);
			send_tick(px, 1'b0);
		end
		send_tick(32'hFFFF_FFFF, 1'b0);
		send_tick(32'h0000_0000, 1'b0);
		send_tick(32'h7FFF_FFFF, 1'b0);
		send_tick(32'hFFFF_FFFF, 1'b1);
	endtask

	// Shortest period, period zero, the largest period, and a period cut short
	// in the middle of a series.
	task automatic test_period_extremes();
		set_period(16'd1);
		send_tick(32'd100, 1'b1);
		send_tick(32'd100, 1'b0);
		send_tick(32'd50, 1'b0);
		send_tick(32'd80, 1'b0);
		set_period(16'd0);
		send_tick(32'd0, 1'b0);
		send_tick(32'hFFFF_FFFF, 1'b0);
		set_period(16'hFFFF);
		send_tick(32'd5, 1'b1);
		send_tick(32'd9, 1'b0);
		send_tick(32'd3, 1'b0);
		set_period(16'd2);
		send_tick(32'd7, 1'b0);
		send_tick(32'd2, 1'b0);
	endtask

	// Series of random shape at one period: mostly long enough to smooth,
	// some cut short, a few noisy prices and stray restarts.
	task automatic run_phase(logic [PERIOD_W-1:0] period, int unsigned count);
		int unsigned            sent;
		int unsigned            len;
		int unsigned            roll;
		logic [COUNT_W:0]       p;
		walk_t                  mode;
		logic [SRC_PRICE_W-1:0] px;
		logic                   restart;
		set_period(period);
		p = {2'b00, period};
		if (p == 0)
			p = (COUNT_W+1)'(1);
		sent = 0;
		while (sent < count) begin
			roll = $urandom_range(0, 99);
			len  = (roll < 85) ? p + 1 + $urandom_range(0, 40) : $urandom_range(1, p);
			roll = $urandom_range(0, 99);
			mode = (roll < 10) ? WALK_NOISE : (roll < 55) ? WALK_SMALL :
			       (roll < 70) ? WALK_UP : (roll < 85) ? WALK_DOWN : WALK_FLAT;
			// Most series open with a restart; some carry on from the last one.
			restart = ($urandom_range(0, 7) != 0);
			px = restart ? $urandom() : next_price(mode, walk_price);
			for (int i = 0; i < len; i++) begin
				if (i > 0) begin
					px      = next_price(mode, px);
					restart = 1'b0;
					roll    = $urandom_range(0, 99);
					if (roll < 3)
						px = $urandom();
					else if (roll == 3)
						restart = 1'b1;
				end
				send_tick(px, restart);
			end
			sent += len;
		end
	endtask

	task automatic test_random_phases();
		run_phase(16'd14, 250);
		run_phase(16'd1, 120);
		run_phase(16'd2, 120);
		run_phase(16'd3, 100);
		run_phase(16'd5, 120);
		run_phase(16'd9, 150);
		run_phase(16'd27, 200);
		run_phase(16'd300, 300);
		run_phase(PERIOD_W'($urandom_range(1, 20)), 100);
	endtask

	// Long output stall while beats keep coming, then a run with no idling.
	task automatic test_backpressure();
		set_period(16'd4);
		hold_cycles  = 600;
		hold_request = 1'b1;
		no_idle      = 1'b1;
		send_tick($urandom(), 1'b1);
		for (int i = 0; i < 15; i++)
			send_tick(next_price(WALK_SMALL, walk_price), 1'b0);
		// The sender pauses here until every pending beat has come back.
		wait_drained();
		send_tick($urandom(), 1'b1);
		for (int i = 0; i < 60; i++)
			send_tick(next_price(WALK_SMALL, walk_price), 1'b0);
		no_idle = 1'b0;
	endtask

	// Output side: random stalls, plus a long hold-off on request.
	initial begin
		int unsigned hold;
		rsi_ch.ready = 1'b0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rsi_ch.ready = 1'b0;
				repeat (hold_cycles) @(negedge clk);
			end
			if (hold > 0) begin
				rsi_ch.ready = 1'b0;
				hold--;
			end else begin
				rsi_ch.ready = 1'b1;
				hold = no_idle ? 0 : idle_len();
			end
		end
	end

	// Compare each accepted index beat with the oldest expectation.
	always @(posedge clk) begin : check_beat
		rsi_beat_t got;
		rsi_beat_t want;
		if (arst_n && rsi_ch.valid && rsi_ch.ready) begin
			got.rsi_value = rsi_ch.rsi_value;
			got.ready_res = rsi_ch.ready_res;
			if (rsi_expected.size() == 0) begin
				note_mismatch("index beat with nothing expected", '0, got);
			end else begin
				want = rsi_expected.pop_front();
				if (got.rsi_value !== want.rsi_value || got.ready_res !== want.ready_res)
					note_mismatch("index beat", want, got);
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if ((tick_ch.valid && tick_ch.ready) || (rsi_ch.valid && rsi_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		period_we       = 1'b0;
		period_wdata    = '0;
		tick_ch.valid   = 1'b0;
		tick_ch.price   = '0;
		tick_ch.restart = 1'b0;
		hold_request    = 1'b0;
		hold_cycles     = 0;
		no_idle         = 1'b0;
		mismatch_count  = 0;
		idle_cycles     = 0;
		walk_price      = '0;
		model_period     = PERIOD_RESET;
		model_last_price = '0;
		model_seen       = '0;
		model_gain_avg   = '0;
		model_loss_avg   = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_period_extremes();
		test_random_phases();
		test_backpressure();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && rsi_expected.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== relative_strength_index_unit.f =====
hw/rtl/rsi_pkg.sv
hw/rtl/rsi_tick_if.sv
hw/rtl/rsi_result_if.sv
hw/rtl/rsi_div.sv
hw/rtl/relative_strength_index_unit.sv
tb/relative_strength_index_unit_tb.sv
